[rtl/cmk_pkg.sv]
package cmk_pkg;

  localparam int NUM_COLS = 4;
  localparam int ATTR_W   = 32;
  localparam int RANK_W   = 3;
  localparam int COL_W    = 2;

  // rank value of a column that has not been clicked
  localparam logic [RANK_W-1:0] NO_CLICK = 3'd4;

  localparam logic CMD_CLICK  = 1'b0;
  localparam logic CMD_RECORD = 1'b1;

  typedef logic [ATTR_W-1:0] attr_t;
  typedef attr_t [NUM_COLS-1:0] rec_t;

  // one sort key: which column sits at this rank, and its direction
  typedef struct packed {
    logic             used;
    logic [COL_W-1:0] col;
    logic             desc;
  } key_t;

  // index 0 is the most significant key
  typedef key_t [NUM_COLS-1:0] key_cfg_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_t;

endpackage

[rtl/click_ordered_multikey_sorter.sv]
// Channel  | Handshake            | Beat contents
// ---------+----------------------+---------------------------------------------
// in_      | in_valid / in_stall  | cmd, clicked_column, attr_zero..three, final
// out_     | out_valid / out_stall| attr_zero..three, end_of_run
//
// Cycles: clicks and records are taken one a cycle while loading. A final record
// starts an odd-even transposition sort over the cell chain: n phases for n
// stored records, one phase a cycle. Records then leave from cell 0, one beat a
// cycle as out_stall allows, the chain shifting down a place per beat; once the
// chain is empty the click keys clear and loading resumes.
// Reset: synchronous, active low; clears the click state and the fill count.
// Stalls: in_stall is high throughout sort and emission; out_stall freezes cell 0.
module click_ordered_multikey_sorter #(
  parameter int RECORD_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [1:0]  in_clicked_column,
  input  logic signed [31:0] in_attr_zero,
  input  logic signed [31:0] in_attr_one,
  input  logic signed [31:0] in_attr_two,
  input  logic signed [31:0] in_attr_three,
  input  logic        in_final_record,

  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_attr_zero,
  output logic signed [31:0] out_attr_one,
  output logic signed [31:0] out_attr_two,
  output logic signed [31:0] out_attr_three,
  output logic        out_end_of_run
);

  localparam int CW = $clog2(RECORD_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_t;

  state_t        state_r;
  logic [CW-1:0] count_r;   // records held in the chain
  logic [CW-1:0] phase_r;   // sort phases done

  logic in_acc, out_acc;
  logic rec_beat, load_en, sort_run, click_clear;

  cmk_pkg::key_cfg_t keys;
  cmk_pkg::rec_t     in_rec;
  cmk_pkg::rec_t     cell_q [RECORD_DEPTH];
  cmk_pkg::cell_op_t cell_op [RECORD_DEPTH];

  logic [RECORD_DEPTH-2:0] b_first;
  logic [RECORD_DEPTH-2:0] swap;

  assign in_stall  = state_r != ST_LOAD;
  assign out_valid = (state_r == ST_EMIT) && (count_r != '0);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  assign rec_beat    = in_acc && (in_cmd == cmk_pkg::CMD_RECORD);
  // a record beyond the chain's depth is dropped, though its final flag counts
  assign load_en     = rec_beat && (count_r < CW'(RECORD_DEPTH));
  assign sort_run    = (state_r == ST_SORT) && (phase_r != count_r);
  assign click_clear = (state_r == ST_EMIT) && (count_r == '0);

  assign in_rec[0] = in_attr_zero;
  assign in_rec[1] = in_attr_one;
  assign in_rec[2] = in_attr_two;
  assign in_rec[3] = in_attr_three;

  cmk_click u_click (
    .clk       (clk),
    .rst_n     (rst_n),
    .click_en  (in_acc && (in_cmd == cmk_pkg::CMD_CLICK)),
    .click_col (in_clicked_column),
    .clear     (click_clear),
    .keys      (keys)
  );

  // comparator between each neighbouring pair; even phases pair (0,1),(2,3)..,
  // odd phases (1,2),(3,4).. Only strict misorder swaps, so ties keep arrival order.
  for (genvar p = 0; p < RECORD_DEPTH - 1; p++) begin : g_pair
    cmk_cmp u_cmp (
      .keys    (keys),
      .rec_a   (cell_q[p]),
      .rec_b   (cell_q[p+1]),
      .b_first (b_first[p])
    );
    assign swap[p] = sort_run && (phase_r[0] == 1'((p % 2)))
                     && (CW'(p + 1) < count_r) && b_first[p];
  end

  for (genvar i = 0; i < RECORD_DEPTH; i++) begin : g_cell
    cmk_pkg::rec_t left_d, right_d;
    logic          swap_up, swap_dn;

    if (i == 0) begin : g_first
      assign left_d  = '0;
      assign swap_up = 1'b0;
    end else begin : g_mid_l
      assign left_d  = cell_q[i-1];
      assign swap_up = swap[i-1];
    end

    if (i == RECORD_DEPTH - 1) begin : g_last
      assign right_d = '0;
      assign swap_dn = 1'b0;
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
      assign swap_dn = swap[i];
    end

    always_comb begin
      cell_op[i] = cmk_pkg::CELL_HOLD;
      if (load_en && (CW'(i) == count_r)) begin
        cell_op[i] = cmk_pkg::CELL_LOAD;
      end else if (swap_dn || out_acc) begin
        cell_op[i] = cmk_pkg::CELL_FROM_RIGHT;
      end else if (swap_up) begin
        cell_op[i] = cmk_pkg::CELL_FROM_LEFT;
      end
    end

    cmk_cell u_cell (
      .clk        (clk),
      .op         (cell_op[i]),
      .load_data  (in_rec),
      .left_data  (left_d),
      .right_data (right_d),
      .data_q     (cell_q[i])
    );
  end

  // cell 0 is the output register
  assign out_attr_zero  = cell_q[0][0];
  assign out_attr_one   = cell_q[0][1];
  assign out_attr_two   = cell_q[0][2];
  assign out_attr_three = cell_q[0][3];
  assign out_end_of_run = count_r == CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      phase_r <= '0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (load_en) begin
            count_r <= count_r + 1'b1;
          end
          if (rec_beat && in_final_record) begin
            state_r <= ST_SORT;
            phase_r <= '0;
          end
        end
        ST_SORT: begin
          if (phase_r == count_r) begin
            state_r <= ST_EMIT;
          end else begin
            phase_r <= phase_r + 1'b1;
          end
        end
        ST_EMIT: begin
          if (count_r == '0) begin
            state_r <= ST_LOAD;
          end else if (out_acc) begin
            count_r <= count_r - 1'b1;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  // no input is taken while sorted records are going out
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during emission");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(RECORD_DEPTH))
    else $error("record count beyond chain depth");

  a_count_frozen_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SORT) |=> (count_r == $past(count_r)))
    else $error("record count moved during sort");

  a_run_ends_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_end_of_run) |=> (count_r == '0) && !out_valid)
    else $error("records left after last beat");

endmodule

[rtl/cmk_click.sv]
module cmk_click (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      click_en,
  input  logic [cmk_pkg::COL_W-1:0] click_col,
  input  logic                      clear,
  output cmk_pkg::key_cfg_t         keys
);

  logic [cmk_pkg::RANK_W-1:0] rank_r [cmk_pkg::NUM_COLS];
  logic [cmk_pkg::RANK_W-1:0] rank_nxt [cmk_pkg::NUM_COLS];
  logic [cmk_pkg::NUM_COLS-1:0] desc_r, desc_nxt;
  logic [cmk_pkg::RANK_W-1:0] prev_r, prev_nxt;
  logic [cmk_pkg::RANK_W-1:0] old_rank;

  always_comb begin
    old_rank = rank_r[click_col];
    rank_nxt = rank_r;
    desc_nxt = desc_r;
    prev_nxt = prev_r;
    if (clear) begin
      for (int c = 0; c < cmk_pkg::NUM_COLS; c++) begin
        rank_nxt[c] = cmk_pkg::NO_CLICK;
      end
      desc_nxt = '0;
      prev_nxt = cmk_pkg::NO_CLICK;
    end else if (click_en) begin
      // columns more recent than the clicked one move down a place
      for (int c = 0; c < cmk_pkg::NUM_COLS; c++) begin
        if (rank_r[c] < old_rank) begin
          rank_nxt[c] = rank_r[c] + 1'b1;
        end
      end
      rank_nxt[click_col] = '0;
      if (prev_r == {1'b0, click_col}) begin
        desc_nxt[click_col] = ~desc_r[click_col];
      end else begin
        desc_nxt[click_col] = 1'b0;
      end
      prev_nxt = {1'b0, click_col};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < cmk_pkg::NUM_COLS; c++) begin
        rank_r[c] <= cmk_pkg::NO_CLICK;
      end
      desc_r <= '0;
      prev_r <= cmk_pkg::NO_CLICK;
    end else begin
      rank_r <= rank_nxt;
      desc_r <= desc_nxt;
      prev_r <= prev_nxt;
    end
  end

  // invert rank table: key r names the column holding rank r
  always_comb begin
    for (int r = 0; r < cmk_pkg::NUM_COLS; r++) begin
      keys[r] = '0;
      for (int c = 0; c < cmk_pkg::NUM_COLS; c++) begin
        if (rank_r[c] == cmk_pkg::RANK_W'(r)) begin
          keys[r].used = 1'b1;
          keys[r].col  = cmk_pkg::COL_W'(c);
          keys[r].desc = desc_r[c];
        end
      end
    end
  end

endmodule

[rtl/cmk_cmp.sv]
module cmk_cmp (
  input  cmk_pkg::key_cfg_t keys,
  input  cmk_pkg::rec_t     rec_a,
  input  cmk_pkg::rec_t     rec_b,
  output logic              b_first
);

  logic [cmk_pkg::NUM_COLS-1:0] differ;
  logic [cmk_pkg::NUM_COLS-1:0] b_less;
  logic                         decided;

  always_comb begin
    for (int c = 0; c < cmk_pkg::NUM_COLS; c++) begin
      differ[c] = rec_a[c] != rec_b[c];
      b_less[c] = $signed(rec_b[c]) < $signed(rec_a[c]);
    end
  end

  // first key that tells the two apart decides; equal records stay put
  always_comb begin
    b_first = 1'b0;
    decided = 1'b0;
    for (int r = 0; r < cmk_pkg::NUM_COLS; r++) begin
      if (!decided && keys[r].used && differ[keys[r].col]) begin
        decided = 1'b1;
        b_first = keys[r].desc ? ~b_less[keys[r].col] : b_less[keys[r].col];
      end
    end
  end

endmodule

[rtl/cmk_cell.sv]
module cmk_cell (
  input  logic              clk,
  input  cmk_pkg::cell_op_t op,
  input  cmk_pkg::rec_t     load_data,
  input  cmk_pkg::rec_t     left_data,
  input  cmk_pkg::rec_t     right_data,
  output cmk_pkg::rec_t     data_q
);

  cmk_pkg::rec_t data_r, data_nxt;

  always_comb begin
    unique case (op)
      cmk_pkg::CELL_LOAD:       data_nxt = load_data;
      cmk_pkg::CELL_FROM_LEFT:  data_nxt = left_data;
      cmk_pkg::CELL_FROM_RIGHT: data_nxt = right_data;
      default:                  data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

[tb/sort_checker.sv]
module sort_checker
  import cmk_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_cmd,
  input  logic [COL_W-1:0]   in_clicked_column,
  input  logic signed [31:0] in_attr_zero,
  input  logic signed [31:0] in_attr_one,
  input  logic signed [31:0] in_attr_two,
  input  logic signed [31:0] in_attr_three,
  input  logic               in_final_record,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_attr_zero,
  input  logic signed [31:0] out_attr_one,
  input  logic signed [31:0] out_attr_two,
  input  logic signed [31:0] out_attr_three,
  input  logic               out_end_of_run,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    rec_t rec;
    logic last;
  } sorted_beat_t;

  // click state and the records of the open set
  logic [RANK_W-1:0] col_rank [NUM_COLS];
  logic              col_desc [NUM_COLS];
  logic [RANK_W-1:0] last_click;
  rec_t              held [DEPTH];
  int                held_cnt;

  sorted_beat_t      sorted_q [$];
  int                err_cnt = 0;

  function automatic void clear_set();
    for (int c = 0; c < NUM_COLS; c++) begin
      col_rank[c] = NO_CLICK;
      col_desc[c] = 1'b0;
    end
    last_click = NO_CLICK;
    held_cnt   = 0;
  endfunction

  function automatic void note_click(logic [COL_W-1:0] col);
    logic [RANK_W-1:0] old_rank;
    old_rank = col_rank[col];
    for (int c = 0; c < NUM_COLS; c++)
      if (col_rank[c] < old_rank) col_rank[c] = col_rank[c] + 1'b1;
    col_rank[col] = '0;
    // same column twice running flips direction, otherwise ascending
    if (last_click == RANK_W'(col)) col_desc[col] = ~col_desc[col];
    else col_desc[col] = 1'b0;
    last_click = RANK_W'(col);
  endfunction

  // -1 if a sorts ahead of b, 1 if after, 0 on a full tie
  function automatic int key_order(rec_t a, rec_t b);
    for (int r = 0; r < NUM_COLS; r++)
      for (int c = 0; c < NUM_COLS; c++)
        if (col_rank[c] == RANK_W'(r) && a[c] != b[c]) begin
          if ($signed(a[c]) < $signed(b[c])) return col_desc[c] ? 1 : -1;
          else return col_desc[c] ? -1 : 1;
        end
    return 0;
  endfunction

  // stable insertion sort of the held set into the expected beats
  function automatic void predict_emission();
    int           order [DEPTH];
    int           j;
    sorted_beat_t b;
    for (int i = 0; i < held_cnt; i++) begin
      j = i;
      while (j > 0 && key_order(held[i], held[order[j-1]]) < 0) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (int i = 0; i < held_cnt; i++) begin
      b.rec  = held[order[i]];
      b.last = (i + 1 == held_cnt);
      sorted_q.push_back(b);
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    sorted_beat_t want;
    if (!rst_n) begin
      clear_set();
      sorted_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (sorted_q.size() == 0) begin
          $display("%0t: output beat with nothing expected, got %h %h %h %h %b", $time,
                   out_attr_zero, out_attr_one, out_attr_two, out_attr_three, out_end_of_run);
          err_cnt++;
        end else begin
          want = sorted_q.pop_front();
          check_field("attr_zero", want.rec[0], out_attr_zero);
          check_field("attr_one", want.rec[1], out_attr_one);
          check_field("attr_two", want.rec[2], out_attr_two);
          check_field("attr_three", want.rec[3], out_attr_three);
          check_field("end_of_run", 32'(want.last), 32'(out_end_of_run));
        end
      end
      if (in_valid && !in_stall) begin
        if (in_cmd == CMD_CLICK) begin
          note_click(in_clicked_column);
        end else begin
          // a full store drops the beat, but a final one still closes the set
          if (held_cnt < DEPTH) begin
            held[held_cnt] = {in_attr_three, in_attr_two, in_attr_one, in_attr_zero};
            held_cnt++;
          end
          if (in_final_record) begin
            predict_emission();
            clear_set();
          end
        end
      end
    end
    mismatches  <= err_cnt;
    outstanding <= sorted_q.size();
  end

endmodule

[tb/testbench.sv]
module testbench;
  import cmk_pkg::*;

  localparam int DEPTH        = 64;
  localparam int DIRECTED     = 25;
  localparam int RANDOM_ITEMS = 145;

  logic               clk               = 1'b0;
  logic               rst_n             = 1'b0;
  logic               in_valid          = 1'b0;
  logic               in_stall;
  logic               in_cmd            = CMD_CLICK;
  logic [COL_W-1:0]   in_clicked_column = '0;
  logic signed [31:0] in_attr_zero      = '0;
  logic signed [31:0] in_attr_one       = '0;
  logic signed [31:0] in_attr_two       = '0;
  logic signed [31:0] in_attr_three     = '0;
  logic               in_final_record   = 1'b0;
  logic               out_valid;
  logic               out_stall         = 1'b1;
  logic signed [31:0] out_attr_zero;
  logic signed [31:0] out_attr_one;
  logic signed [31:0] out_attr_two;
  logic signed [31:0] out_attr_three;
  logic               out_end_of_run;

  int                 mismatches;
  int                 outstanding;

  // set near the end of the run: from then on neither side idles
  logic               quiet_tail = 1'b0;
  int                 beats_sent = 0;
  logic [COL_W-1:0]   prev_col   = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  click_ordered_multikey_sorter #(.RECORD_DEPTH(DEPTH)) dut (.*);

  sort_checker #(.DEPTH(DEPTH)) checker_i (.*);

  // --------------------------------------------------------------------------
  // Beat helpers
  // --------------------------------------------------------------------------

  function automatic rec_t make_rec(attr_t a0, attr_t a1, attr_t a2, attr_t a3);
    return {a3, a2, a1, a0};
  endfunction

  // biased towards a small spread so that keys tie often, with the extremes
  // and fully random words mixed in so every bit toggles
  function automatic attr_t pick_attr();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom();
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4:       return 32'hffff_ffff;
      default: return attr_t'($urandom_range(0, 6)) - 32'd3;
    endcase
  endfunction

  function automatic rec_t random_rec();
    return make_rec(pick_attr(), pick_attr(), pick_attr(), pick_attr());
  endfunction

  // Offers one beat and holds it until the block takes it. An optional idle
  // gap goes in front, never once the tail has begun.
  // The gap is decided before looking at in_stall, so valid never follows it.
  task automatic offer_beat(input logic cmd, input logic [COL_W-1:0] col,
                            input rec_t attrs, input logic fin);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_cmd            <= cmd;
    in_clicked_column <= col;
    in_attr_zero      <= attrs[0];
    in_attr_one       <= attrs[1];
    in_attr_two       <= attrs[2];
    in_attr_three     <= attrs[3];
    in_final_record   <= fin;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // click beats carry junk in the record fields, which the block must ignore
  task automatic click(input logic [COL_W-1:0] col);
    prev_col = col;
    offer_beat(CMD_CLICK, col, random_rec(), 1'($urandom_range(0, 1)));
  endtask

  // and record beats carry a junk column
  task automatic load(input rec_t r, input logic fin);
    offer_beat(CMD_RECORD, COL_W'($urandom_range(0, 3)), r, fin);
  endtask

  // a third of random clicks repeat the last one, to hit the direction toggle
  task automatic random_click();
    if ($urandom_range(0, 2) == 0) click(prev_col);
    else click(COL_W'($urandom_range(0, 3)));
  endtask

  // Well-formed set: some clicks, then n_rec records with the last marked
  // final. Now and then a click lands between records.
  task automatic random_set(input int n_rec);
    repeat ($urandom_range(0, 5)) random_click();
    for (int i = 0; i < n_rec; i++) begin
      if ($urandom_range(0, 5) == 0) random_click();
      load(random_rec(), i == n_rec - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  initial begin
    int drain;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // lone record, nothing clicked, all four extremes in one beat
    load(make_rec(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff), 1'b1);

    // no click at all: arrival order must hold whatever the values
    load(make_rec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 1'b0);
    load(make_rec(32'h0000_0000, 32'h0000_0001, 32'h8000_0000, 32'hffff_ffff), 1'b0);
    load(make_rec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b1);

    // column 2 clicked twice (descending), then column 0 ascending on top;
    // clicks on columns 3 and 1 come before the final record and lead the keys
    click(2'd2);
    click(2'd2);
    click(2'd0);
    load(make_rec(32'h7fff_ffff, 32'h1, 32'h0000_0001, 32'h5), 1'b0);
    load(make_rec(32'h8000_0000, 32'h2, 32'hffff_ffff, 32'h6), 1'b0);
    load(make_rec(32'h8000_0000, 32'h3, 32'h0000_0005, 32'h7), 1'b0);
    load(make_rec(32'h0000_0000, 32'h4, 32'h0000_0000, 32'h8), 1'b0);
    // this set has not closed yet - the final is the next one
    click(2'd3);
    click(2'd1);
    load(make_rec(32'h1, 32'h1, 32'h1, 32'h1), 1'b1);

    // columns 0, 2 and 1 clicked, column 2 toggled down and back up; a click on
    // column 1 between records reorders the keys at emission time
    click(2'd0);
    click(2'd2);
    click(2'd2);
    click(2'd2);
    load(make_rec(32'h5, 32'h0, 32'hffff_fffe, 32'h9), 1'b0);
    click(2'd1);
    load(make_rec(32'h4, 32'h0, 32'hffff_fffe, 32'h3), 1'b0);
    load(make_rec(32'h4, 32'hffff_ffff, 32'h7fff_ffff, 32'h3), 1'b1);

    // stability: one key, all tied, the rest differ
    click(2'd1);
    load(make_rec(32'h3, 32'h9, 32'h1, 32'h0), 1'b0);
    load(make_rec(32'h2, 32'h9, 32'h2, 32'h0), 1'b1);

    // store overrun: the 65th record is dropped, the 66th is dropped but
    // still closes the set
    random_set(DEPTH + 2);

    while (beats_sent < DIRECTED + RANDOM_ITEMS) begin
      if (beats_sent > DIRECTED + RANDOM_ITEMS - 35) quiet_tail <= 1'b1;
      random_set($urandom_range(1, 8));
    end
    in_valid <= 1'b0;

    // the checker's pending count is registered, so let it update before looking
    @(posedge clk);
    drain = 0;
    while (outstanding != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (64) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver
  // --------------------------------------------------------------------------
  // Holds off for a long stretch first: the opening sets close, emission
  // blocks and the block stalls its input while the sender keeps offering.
  // After that, stall bursts alternate with clear runs, some long.
  initial begin
    int run;
    while (!rst_n) @(posedge clk);
    repeat (400) @(posedge clk);
    while (!quiet_tail) begin
      case ($urandom_range(0, 3))
        0: begin
          out_stall <= 1'b1;
          run = $urandom_range(1, 16);
        end
        1: begin
          out_stall <= 1'b0;
          run = $urandom_range(20, 80);
        end
        default: begin
          out_stall <= 1'b0;
          run = $urandom_range(1, 16);
        end
      endcase
      repeat (run) @(posedge clk);
    end
    out_stall <= 1'b0;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #200000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
